### rtl/cbts_pkg.sv
// Package with shared constants for the CAN bit timing search.
package cbts_pkg;
  localparam int CLK_W = 28;
  localparam int RATE_W = 26;
  localparam int PT_W = 16;
  localparam int PRE_W = 25;
  localparam int Q_W = 5;
  localparam int S1_W = 5;
  localparam int S2_W = 4;
  localparam int AP_W = 10;
  localparam int D_W = 28;
  localparam int MIN_QUANTA_DEF = 8;
  localparam int MAX_QUANTA_DEF = 25;
  localparam int MAX_SEG1_DEF = 16;
  localparam int MAX_SEG2_DEF = 8;
  localparam logic [CLK_W-1:0] CLOCK_RESET = 28'd42000000;
  localparam int POINT_SCALE = 1000;
endpackage

### rtl/can_bit_timing_search.sv
// The pipeline holds the divider input register and 28 divider stages, one reciprocal
// multiply stage, 3 search stages and the output register.
// Throughput: one beat per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage.
// The 28-stage divider, one quotient bit per stage, sets the latency.
// Reset is synchronous and active low; it clears valid bits and loads the clock register.
module can_bit_timing_search #(
  parameter int MIN_QUANTA = cbts_pkg::MIN_QUANTA_DEF,
  parameter int MAX_QUANTA = cbts_pkg::MAX_QUANTA_DEF,
  parameter int MAX_SEG1 = cbts_pkg::MAX_SEG1_DEF,
  parameter int MAX_SEG2 = cbts_pkg::MAX_SEG2_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cbts_pkg::CLK_W-1:0]  cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cbts_pkg::RATE_W-1:0] in_baud_rate,
  input  logic [cbts_pkg::PT_W-1:0]   in_desired_sample_point,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_found,
  output logic                        out_zero_rate,
  output logic [cbts_pkg::Q_W-1:0]    out_quanta_total,
  output logic [cbts_pkg::PRE_W-1:0]  out_prescaler,
  output logic [cbts_pkg::S1_W-1:0]   out_seg1_quanta,
  output logic [cbts_pkg::S2_W-1:0]   out_seg2_quanta,
  output logic [cbts_pkg::AP_W-1:0]   out_achieved_point,
  output logic [cbts_pkg::PT_W-1:0]   out_point_error
);
  import cbts_pkg::*;

  localparam int NQ = MAX_QUANTA - MIN_QUANTA + 1;

  typedef struct packed {
    logic             ok;
    logic [Q_W-1:0]   q;
    logic [PRE_W-1:0] pre;
    logic [S1_W-1:0]  s1;
    logic [S2_W-1:0]  s2;
    logic [AP_W-1:0]  pt;
    logic [PT_W-1:0]  err;
  } cand_t;

  logic [CLK_W-1:0] clk_hz_r;
  logic adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= CLOCK_RESET;
    end else if (cfg_we) begin
      clk_hz_r <= cfg_wdata;
    end
  end

  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic             dv;
  logic [D_W-1:0]   dq;
  logic [PT_W-1:0]  dpt;
  logic             dzero;

  cbts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .num      (clk_hz_r),
    .den      (in_baud_rate),
    .tag_pt   (in_desired_sample_point),
    .tag_zero (in_baud_rate == '0),
    .out_vld  (dv),
    .quo      (dq),
    .out_pt   (dpt),
    .out_zero (dzero)
  );

  // Stage M: quotient by every quanta count through reciprocal multiplication.
  logic            m_v_r, m_zero_r;
  logic [D_W-1:0]  m_d_r;
  logic [PT_W-1:0] m_pt_r;
  logic [D_W-1:0]  m_quo_r [NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_rcp
    localparam int Q = MIN_QUANTA + k;
    localparam int SH = D_W + $clog2(Q);
    localparam longint unsigned RCP_FULL = ((64'd1 << SH) + 64'(Q) - 64'd1) / 64'(Q);
    localparam logic [D_W+1:0] RCP = (D_W+2)'(RCP_FULL);
    logic [2*D_W+7:0] prod;
    assign prod = dq * RCP;
    always_ff @(posedge clk) begin
      if (adv) begin
        m_quo_r[k] <= prod[SH +: D_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= dv;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      m_zero_r <= dzero;
      m_d_r <= dq;
      m_pt_r <= dpt;
    end
  end

  // Stage A: divisibility per quanta count and best candidate within that count.
  logic            a_v_r, a_zero_r;
  cand_t           a_c_r [NQ];
  logic [NQ-1:0]   a_div_r;

  for (genvar k = 0; k < NQ; k++) begin : g_q
    localparam int Q = MIN_QUANTA + k;
    cand_t best;
    logic  dv_ok;
    assign dv_ok = (m_quo_r[k] * D_W'(Q) == m_d_r) && (m_quo_r[k] != '0);
    always_comb begin
      int s1, s2, ap;
      logic [PT_W:0] e;
      best = '0;
      best.pre = m_quo_r[k][PRE_W-1:0];
      for (s1 = 1; s1 <= MAX_SEG1; s1++) begin
        s2 = Q - 1 - s1;
        if (s2 >= 1 && s2 <= MAX_SEG2) begin
          ap = (POINT_SCALE * (1 + s1)) / Q;
          e = ({1'b0, PT_W'(ap)} >= {1'b0, m_pt_r}) ? {1'b0, PT_W'(ap)} - {1'b0, m_pt_r}
                                                   : {1'b0, m_pt_r} - {1'b0, PT_W'(ap)};
          if (!best.ok || e[PT_W-1:0] < best.err) begin
            best.ok = 1'b1;
            best.q = Q_W'(Q);
            best.s1 = S1_W'(s1);
            best.s2 = S2_W'(s2);
            best.pt = AP_W'(ap);
            best.err = e[PT_W-1:0];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        a_c_r[k] <= best;
        a_div_r[k] <= dv_ok && best.ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= m_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      a_zero_r <= m_zero_r;
    end
  end

  // Stage B: ordered minimum over groups of four quanta counts.
  localparam int NG = (NQ + 3) / 4;
  logic            b_v_r, b_zero_r;
  cand_t           b_c_r [NG];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    cand_t m;
    always_comb begin
      m = '0;
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < NQ) begin
          if (a_div_r[g*4+j] && (!m.ok || a_c_r[g*4+j].err < m.err)) begin
            m = a_c_r[g*4+j];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        b_c_r[g] <= m;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      b_zero_r <= a_zero_r;
    end
  end

  // Stage C: final ordered minimum.
  cand_t           c_best;
  logic            c_v_r, c_zero_r;
  cand_t           c_c_r;

  always_comb begin
    c_best = '0;
    for (int g = 0; g < NG; g++) begin
      if (b_c_r[g].ok && (!c_best.ok || b_c_r[g].err < c_best.err)) begin
        c_best = b_c_r[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c_zero_r <= b_zero_r;
      c_c_r <= c_best;
    end
  end

  logic ov_r;
  logic found_r, zero_r;
  logic [Q_W-1:0] q_r;
  logic [PRE_W-1:0] pre_r;
  logic [S1_W-1:0] s1_r;
  logic [S2_W-1:0] s2_r;
  logic [AP_W-1:0] ap_r;
  logic [PT_W-1:0] err_r;
  logic hit;
  assign hit = c_c_r.ok && !c_zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= c_v_r;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      found_r <= hit;
      zero_r <= c_zero_r;
      q_r <= hit ? c_c_r.q : '0;
      pre_r <= hit ? c_c_r.pre : '0;
      s1_r <= hit ? c_c_r.s1 : '0;
      s2_r <= hit ? c_c_r.s2 : '0;
      ap_r <= hit ? c_c_r.pt : '0;
      err_r <= hit ? c_c_r.err : '0;
    end
  end

  assign out_valid = ov_r;
  assign out_found = found_r;
  assign out_zero_rate = zero_r;
  assign out_quanta_total = q_r;
  assign out_prescaler = pre_r;
  assign out_seg1_quanta = s1_r;
  assign out_seg2_quanta = s2_r;
  assign out_achieved_point = ap_r;
  assign out_point_error = err_r;

`ifndef ASSERT_OFF
  a_zero_nf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_rate |-> !out_found) else $error("zero rate with found");
  a_nf_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_quanta_total == '0 && out_prescaler == '0)
    else $error("fields not cleared");
  a_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |->
      out_quanta_total == Q_W'(out_seg1_quanta + out_seg2_quanta + 1'b1))
    else $error("segment sum mismatch");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prescaler))
    else $error("stalled output changed");
`endif
endmodule

### rtl/cbts_div.sv
// Pipelined restoring divider, one quotient bit per stage, with quotient only.
module cbts_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic                       in_vld,
  input  logic [cbts_pkg::CLK_W-1:0] num,
  input  logic [cbts_pkg::RATE_W-1:0] den,
  input  logic [cbts_pkg::PT_W-1:0]  tag_pt,
  input  logic                       tag_zero,
  output logic                       out_vld,
  output logic [cbts_pkg::D_W-1:0]   quo,
  output logic [cbts_pkg::PT_W-1:0]  out_pt,
  output logic                       out_zero
);
  import cbts_pkg::*;
  localparam int N = CLK_W;

  logic [N:0]        vld_r;
  logic [RATE_W:0]   rem_r  [0:N];
  logic [N-1:0]      num_r  [0:N];
  logic [RATE_W-1:0] den_r  [0:N];
  logic [PT_W-1:0]   pt_r   [0:N];
  logic [N:0]        zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[N-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= '0;
      num_r[0] <= num;
      den_r[0] <= den;
      pt_r[0] <= tag_pt;
      zero_r[0] <= tag_zero;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_st
    logic [RATE_W+1:0] sh;
    logic [RATE_W+1:0] df;
    assign sh = {rem_r[i], num_r[i][N-1]};
    assign df = sh - {2'b00, den_r[i]};
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!df[RATE_W+1]) begin
          rem_r[i+1] <= df[RATE_W:0];
          num_r[i+1] <= {num_r[i][N-2:0], 1'b1};
        end else begin
          rem_r[i+1] <= sh[RATE_W:0];
          num_r[i+1] <= {num_r[i][N-2:0], 1'b0};
        end
        den_r[i+1] <= den_r[i];
        pt_r[i+1] <= pt_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  assign out_vld = vld_r[N];
  assign quo = num_r[N];
  assign out_pt = pt_r[N];
  assign out_zero = zero_r[N];
endmodule
